@@ src/lwp_pkg.sv @@
`default_nettype none
package lwp_pkg;

	localparam int MaxDim = 256;

	// Quotient layout of the ratio unit: integer bits below the clamp point
	// plus the fraction bits of a Q.16 result.
	localparam int SatShift = 13;
	localparam int FracBits = 16;
	localparam int DivSteps = SatShift + FracBits;
	localparam int DivLat = DivSteps + 3;

	localparam int QDepth = 4;

	localparam int InW = 304;
	localparam int OutW = 96;

	localparam logic [1:0] RegPanU = 2'd0;
	localparam logic [1:0] RegPanV = 2'd1;
	localparam logic [1:0] RegScaleU = 2'd2;
	localparam logic [1:0] RegScaleV = 2'd3;

	localparam logic signed [65:0] Max32 = 66'sd2147483647;
	localparam logic signed [65:0] Min32 = -66'sd2147483648;

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] v;
		logic [2:0][32:0] opu;
		logic [2:0][32:0] vmu;
		logic [7:0]       col;
		logic [31:0]      a;
		logic [31:0]      b;
		logic [32:0]      amb;
		logic             deg;
	} edge_t;

	typedef struct packed {
		edge_t       e;
		logic [33:0] n0;
		logic [31:0] d0;
		logic [34:0] n1;
		logic [32:0] d1;
	} qent_t;

	typedef struct packed {
		logic [2:0][31:0] p0;
		logic [2:0][32:0] diff;
		logic             deg;
	} span_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] val);
		if (val > Max32) begin
			return 32'sh7fffffff;
		end else if (val < Min32) begin
			return 32'sh80000000;
		end
		return 32'(val);
	endfunction

	function automatic logic [7:0] clamp_idx(input logic [7:0] idx);
		if ({24'b0, idx} > 32'(MaxDim - 1)) begin
			return 8'(MaxDim - 1);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

@@ src/lightmap_texel_world_position.sv @@
// Throughput: one item per cycle while the output is not stalled; every stage is pipelined,
// the three ratio units included. The ratio units resolve one quotient bit per stage, with
// 29 quotient-bit stages each, which sets the depth. A four-entry queue separates the front
// stages from the back, so input keeps flowing while a finished result waits, until the
// queue fills. Reset (arst_n low) clears all valid state and sets the pan registers to zero
// and both scale registers to 32.0.
`default_nettype none
module lightmap_texel_world_position import lwp_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	// origin_x/y/z, u_axis_x/y/z, v_axis_x/y/z, texel_col, texel_row
	input  wire logic [303:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire              m_axis_tready,
	// point_x, point_y, point_z
	output logic [95:0]      m_axis_tdata,
	// degenerate
	output logic             m_axis_tuser,
	input  wire              cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	logic signed [31:0] pan_u_q, pan_v_q;
	logic [23:0]        scale_u_q, scale_v_q;

	logic  push_valid, q_full, pop, q_valid;
	qent_t push_data, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_u_q   <= '0;
			pan_v_q   <= '0;
			scale_u_q <= 24'd8192;
			scale_v_q <= 24'd8192;
		end else if (cfg_we) begin
			case (cfg_addr)
				RegPanU:   pan_u_q   <= $signed(cfg_wdata);
				RegPanV:   pan_v_q   <= $signed(cfg_wdata);
				RegScaleU: scale_u_q <= cfg_wdata[23:0];
				RegScaleV: scale_v_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	lwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.pan_v      (pan_v_q),
		.scale_v    (scale_v_q),
		.push_valid (push_valid),
		.q_full     (q_full),
		.push_data  (push_data)
	);

	lwp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	lwp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.pan_u     (pan_u_q),
		.scale_u   (scale_u_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_point (m_axis_tdata),
		.out_deg   (m_axis_tuser)
	);

endmodule
`default_nettype wire

@@ src/lwp_div.sv @@
`default_nettype none
module lwp_div import lwp_pkg::*; (
	input  wire                      clk,
	input  wire                      en,
	input  wire logic signed [63:0]  num,
	input  wire logic signed [63:0]  den,
	output logic signed [30:0]       quo
);

	logic                neg_a;
	logic [63:0]         un_a;
	logic [63:0]         ud_a;
	logic [DivSteps:0]   neg_q;
	logic [DivSteps:0]   sat_q;
	logic [63:0]         rem_q [DivSteps];
	logic [63:0]         ud_q [DivSteps];
	logic [DivSteps-1:0] bits_q [DivSteps];
	logic [DivSteps-1:0] quo_q [DivSteps+1];
	logic [64:0]         trial [DivSteps];
	logic [DivSteps-1:0] ge;
	logic [63:0]         rnext [DivSteps];
	logic [29:0]         mag;

	always_comb begin
		for (int k = 0; k < DivSteps; k++) begin
			trial[k] = {rem_q[k], bits_q[k][DivSteps-1]};
			ge[k] = trial[k] >= {1'b0, ud_q[k]};
			rnext[k] = ge[k] ? 64'(trial[k] - {1'b0, ud_q[k]}) : trial[k][63:0];
		end
		mag = sat_q[DivSteps] ? (30'(1) << DivSteps) : {1'b0, quo_q[DivSteps]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_a <= num[63] ^ den[63];
			un_a  <= num[63] ? unsigned'(-num) : unsigned'(num);
			ud_a  <= den[63] ? unsigned'(-den) : unsigned'(den);

			// Quotients of 2^SatShift or more clamp to the limit.
			sat_q[0]  <= {SatShift'(0), un_a} >= {ud_a, SatShift'(0)};
			neg_q[0]  <= neg_a;
			rem_q[0]  <= un_a >> SatShift;
			ud_q[0]   <= ud_a;
			bits_q[0] <= {un_a[SatShift-1:0], FracBits'(0)};
			quo_q[0]  <= '0;

			for (int k = 0; k < DivSteps; k++) begin
				quo_q[k+1] <= {quo_q[k][DivSteps-2:0], ge[k]};
				neg_q[k+1] <= neg_q[k];
				sat_q[k+1] <= sat_q[k];
				if (k < DivSteps - 1) begin
					rem_q[k+1]  <= rnext[k];
					ud_q[k+1]   <= ud_q[k];
					bits_q[k+1] <= bits_q[k] << 1;
				end
			end

			quo <= neg_q[DivSteps] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule
`default_nettype wire

@@ src/lwp_front.sv @@
`default_nettype none
module lwp_front import lwp_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire logic [InW-1:0]     in_data,
	input  wire logic signed [31:0] pan_v,
	input  wire logic [23:0]        scale_v,
	output logic                    push_valid,
	input  wire                     q_full,
	output qent_t                   push_data
);

	logic en;
	logic f1_v_s1, f2_v_s2, f3_v_s3;

	logic signed [31:0] oi [3];
	logic signed [31:0] ui [3];
	logic signed [31:0] vi [3];
	logic signed [63:0] puv [3];
	logic signed [63:0] puu [3];
	logic signed [63:0] pvv [3];

	logic signed [55:0] pa_s1 [3];
	logic signed [55:0] pb_s1 [3];
	logic signed [55:0] pc_s1 [3];
	logic [31:0]        rsv_s1;
	edge_t              ep_s1;

	logic signed [31:0] a_s2, b_s2, c_s2;
	logic signed [33:0] ny_s2;
	edge_t              ep_s2;

	qent_t              qe_s3;

	assign en = ~(f3_v_s3 & q_full);
	assign in_ready = en;
	assign push_valid = f3_v_s3 & ~q_full;
	assign push_data = qe_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			oi[k] = $signed(in_data[32*k +: 32]);
			ui[k] = $signed(in_data[96 + 32*k +: 32]);
			vi[k] = $signed(in_data[192 + 32*k +: 32]);
			puv[k] = ui[k] * vi[k];
			puu[k] = ui[k] * ui[k];
			pvv[k] = vi[k] * vi[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v_s1 <= 1'b0;
			f2_v_s2 <= 1'b0;
			f3_v_s3 <= 1'b0;
		end else if (en) begin
			f1_v_s1 <= in_valid;
			f2_v_s2 <= f1_v_s1;
			f3_v_s3 <= f2_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pa_s1[k] <= 56'(puv[k] >>> 8);
				pb_s1[k] <= 56'(puu[k] >>> 8);
				pc_s1[k] <= 56'(pvv[k] >>> 8);
				ep_s1.o[k]   <= in_data[32*k +: 32];
				ep_s1.v[k]   <= in_data[192 + 32*k +: 32];
				ep_s1.opu[k] <= 33'(oi[k]) + 33'(ui[k]);
				ep_s1.vmu[k] <= 33'(vi[k]) - 33'(ui[k]);
			end
			ep_s1.col <= clamp_idx(in_data[295:288]);
			ep_s1.a   <= '0;
			ep_s1.b   <= '0;
			ep_s1.amb <= '0;
			ep_s1.deg <= 1'b0;
			rsv_s1 <= {24'b0, clamp_idx(in_data[303:296])} * {8'b0, scale_v};

			a_s2  <= sat32(66'(pa_s1[0]) + 66'(pa_s1[1]) + 66'(pa_s1[2]));
			b_s2  <= sat32(66'(pb_s1[0]) + 66'(pb_s1[1]) + 66'(pb_s1[2]));
			c_s2  <= sat32(66'(pc_s1[0]) + 66'(pc_s1[1]) + 66'(pc_s1[2]));
			ny_s2 <= $signed({2'b0, rsv_s1}) + 34'(pan_v);
			ep_s2 <= ep_s1;

			// The row-centre half texel cancels against the pan bias, so the
			// left edge parameter is ny / C and the right one (ny - A) / (C - A).
			qe_s3.e.o     <= ep_s2.o;
			qe_s3.e.v     <= ep_s2.v;
			qe_s3.e.opu   <= ep_s2.opu;
			qe_s3.e.vmu   <= ep_s2.vmu;
			qe_s3.e.col   <= ep_s2.col;
			qe_s3.e.a     <= a_s2;
			qe_s3.e.b     <= b_s2;
			qe_s3.e.amb   <= 33'(a_s2) - 33'(b_s2);
			qe_s3.e.deg   <= (c_s2 == 32'sd0) || (c_s2 == a_s2);
			qe_s3.n0      <= ny_s2;
			qe_s3.d0      <= c_s2;
			qe_s3.n1      <= 35'(ny_s2) - 35'(a_s2);
			qe_s3.d1      <= 33'(c_s2) - 33'(a_s2);
		end
	end

endmodule
`default_nettype wire

@@ src/lwp_queue.sv @@
`default_nettype none
module lwp_queue import lwp_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire qent_t push_data,
	output logic       full,
	input  wire        pop,
	output logic       head_valid,
	output qent_t      head
);

	localparam int PtrW = $clog2(QDepth);
	localparam int CntW = $clog2(QDepth + 1);

	qent_t           mem_q [QDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full = cnt_q == CntW'(QDepth);
	assign head_valid = cnt_q != '0;
	assign head = mem_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ src/lwp_back.sv @@
`default_nettype none
module lwp_back import lwp_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     q_valid,
	input  wire qent_t              q_head,
	output logic                    pop,
	input  wire logic signed [31:0] pan_u,
	input  wire logic [23:0]        scale_u,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [OutW-1:0]         out_point,
	output logic                    out_deg
);

	logic en;

	logic signed [30:0] t0, t1, ts;

	logic [DivLat-1:0] ev_q;
	edge_t             ep_q [DivLat];
	edge_t             ed;

	logic               s1_v_s1;
	logic signed [62:0] at0_s1;
	logic signed [63:0] ambt1_s1;
	logic [31:0]        colsu_s1;
	logic signed [62:0] t0v_s1 [3];
	logic signed [63:0] t1w_s1 [3];
	edge_t              ep_s1;

	logic               s2_v_s2;
	logic signed [63:0] nx_s2, dx_s2;
	logic signed [31:0] p0_s2 [3];
	logic signed [31:0] p1_s2 [3];
	logic               deg_s2;

	logic               s3_v_s3;
	logic signed [63:0] n_s3, d_s3;
	span_t              sp_s3;
	logic               sw;

	logic [DivLat-1:0] sv_q;
	span_t             spp_q [DivLat];
	span_t             sd;

	logic               s4_v_s4;
	logic signed [63:0] prod_s4 [3];
	logic signed [31:0] p0_s4 [3];
	logic               deg_s4;

	logic               out_v_s5;
	logic [OutW-1:0]    point_s5;
	logic               deg_s5;

	assign en = ~(out_v_s5 & ~out_ready);
	assign pop = en & q_valid;
	assign ed = ep_q[DivLat-1];
	assign sd = spp_q[DivLat-1];
	assign sw = dx_s2[63];

	assign out_valid = out_v_s5;
	assign out_point = point_s5;
	assign out_deg = deg_s5;

	lwp_div u_div_t0 (
		.clk (clk),
		.en  (en),
		.num (64'($signed(q_head.n0))),
		.den (64'($signed(q_head.d0))),
		.quo (t0)
	);

	lwp_div u_div_t1 (
		.clk (clk),
		.en  (en),
		.num (64'($signed(q_head.n1))),
		.den (64'($signed(q_head.d1))),
		.quo (t1)
	);

	lwp_div u_div_span (
		.clk (clk),
		.en  (en),
		.num (n_s3),
		.den (d_s3),
		.quo (ts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q     <= '0;
			s1_v_s1  <= 1'b0;
			s2_v_s2  <= 1'b0;
			s3_v_s3  <= 1'b0;
			sv_q     <= '0;
			s4_v_s4  <= 1'b0;
			out_v_s5 <= 1'b0;
		end else if (en) begin
			ev_q     <= {ev_q[DivLat-2:0], q_valid};
			s1_v_s1  <= ev_q[DivLat-1];
			s2_v_s2  <= s1_v_s1;
			s3_v_s3  <= s2_v_s2;
			sv_q     <= {sv_q[DivLat-2:0], s3_v_s3};
			s4_v_s4  <= sv_q[DivLat-1];
			out_v_s5 <= s4_v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ep_q[0] <= q_head.e;
			for (int i = 1; i < DivLat; i++) begin
				ep_q[i] <= ep_q[i-1];
			end

			at0_s1   <= $signed(ed.a) * t0;
			ambt1_s1 <= $signed(ed.amb) * t1;
			colsu_s1 <= {24'b0, ed.col} * {8'b0, scale_u};
			for (int k = 0; k < 3; k++) begin
				t0v_s1[k] <= t0 * $signed(ed.v[k]);
				t1w_s1[k] <= t1 * $signed(ed.vmu[k]);
			end
			ep_s1 <= ed;

			// Span numerator and divisor in Q.24 units; the numerator's column term is scaled by scale_u.
			nx_s2 <= $signed({16'b0, colsu_s1, 16'b0}) - $signed({25'b0, scale_u, 15'b0})
				+ (64'(pan_u) <<< 16) - 64'(at0_s1);
			dx_s2 <= (64'($signed(ep_s1.b)) <<< 16) + ambt1_s1 - 64'(at0_s1);
			for (int k = 0; k < 3; k++) begin
				p0_s2[k] <= sat32(66'($signed(ep_s1.o[k])) + 66'(t0v_s1[k] >>> 16));
				p1_s2[k] <= sat32(66'($signed(ep_s1.opu[k])) + 66'(t1w_s1[k] >>> 16));
			end
			deg_s2 <= ep_s1.deg;

			// A negative divisor means the edge ends are reversed along U.
			n_s3 <= sw ? nx_s2 - dx_s2 : nx_s2;
			d_s3 <= sw ? -dx_s2 : dx_s2;
			for (int k = 0; k < 3; k++) begin
				sp_s3.p0[k]   <= sw ? p1_s2[k] : p0_s2[k];
				sp_s3.diff[k] <= sw ? 33'(p0_s2[k]) - 33'(p1_s2[k])
					: 33'(p1_s2[k]) - 33'(p0_s2[k]);
			end
			sp_s3.deg <= deg_s2 | (dx_s2 == 64'sd0);

			spp_q[0] <= sp_s3;
			for (int i = 1; i < DivLat; i++) begin
				spp_q[i] <= spp_q[i-1];
			end

			for (int k = 0; k < 3; k++) begin
				prod_s4[k] <= ts * $signed(sd.diff[k]);
				p0_s4[k]   <= $signed(sd.p0[k]);
			end
			deg_s4 <= sd.deg;

			for (int k = 0; k < 3; k++) begin
				point_s5[32*k +: 32] <= deg_s4 ? 32'b0
					: sat32(66'(p0_s4[k]) + 66'(prod_s4[k] >>> 16));
			end
			deg_s5 <= deg_s4;
		end
	end

endmodule
`default_nettype wire

@@ src/lwp_chk.sv @@
`default_nettype none
module lwp_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [95:0] m_axis_tdata,
	input wire        m_axis_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A degenerate item carries a zero point.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 96'b0)
		else $error("degenerate item with nonzero point");

	// The input side only backs up behind a result the sink has not taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending result");

	// Nothing is presented right out of reset.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid right after reset");

endmodule

bind lightmap_texel_world_position lwp_chk u_lwp_chk (.*);
`default_nettype wire
